### sv/swdhte_pkg.sv
// Package for the serial wire debug host transaction engine.
// Holds item, result and configuration types, codes and a request helper.
// No dependencies.
package swdhte_pkg;

    localparam logic       KIND_START = 1'b0;
    localparam logic       KIND_TICK  = 1'b1;

    localparam logic [2:0] ACK_OK     = 3'd1;
    localparam logic [2:0] ACK_WAIT   = 3'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_ACK     = 2'd1;
    localparam logic [1:0] ERR_RETRIES = 2'd2;

    localparam logic [1:0] CFG_RETRY_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_OVERRUN_MODE = 2'd1;

    localparam logic [15:0] RETRY_LIMIT_RESET = 16'd100;

    localparam logic [7:0] REQ_BASE     = 8'b1000_0001;
    localparam logic [7:0] REQ_AP       = 8'b0000_0010;
    localparam logic [7:0] REQ_READ     = 8'b0000_0100;
    localparam logic [7:0] REQ_ADDR     = 8'b0001_1000;
    localparam logic [7:0] REQ_PARITY   = 8'b0010_0000;

    typedef struct packed {
        logic        kind;
        logic        to_access_port;
        logic        is_read;
        logic [3:0]  reg_offset;
        logic [31:0] write_word;
        logic        line_in;
    } item_t;

    typedef struct packed {
        logic        line_out;
        logic        line_drive;
        logic        busy_res;
        logic        done_res;
        logic        success;
        logic [1:0]  error_code;
        logic [2:0]  last_ack;
        logic [31:0] read_word;
    } result_t;

    typedef struct packed {
        logic [15:0] retry_limit;
        logic        overrun_mode;
    } cfg_t;

    function automatic logic [7:0] build_request(input logic ap, input logic rd,
                                                 input logic [3:0] off);
        logic [7:0] r;
        r = REQ_BASE;
        if (ap)
        begin
            r = r | REQ_AP;
        end
        if (rd)
        begin
            r = r | REQ_READ;
        end
        r = r | ({3'b000, off, 1'b0} & REQ_ADDR);
        if (^r)
        begin
            r = r | REQ_PARITY;
        end
        return r;
    endfunction

endpackage

### sv/swdhte_step.sv
// Transaction state and per-item next-state logic of the engine.
// Depends on swdhte_pkg.
module swdhte_step #(
    parameter int RETRY_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  swdhte_pkg::item_t   item,
    input  swdhte_pkg::cfg_t    cfg,
    output swdhte_pkg::result_t result
);
    import swdhte_pkg::*;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_REQ      = 8'b0000_0010,
        PH_TURN1    = 8'b0000_0100,
        PH_ACK      = 8'b0000_1000,
        PH_RDATA    = 8'b0001_0000,
        PH_TURN_END = 8'b0010_0000,
        PH_WTURN    = 8'b0100_0000,
        PH_WDATA    = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_JUDGE,
        OUT_RETRY
    } outcome_t;

    phase_t                phase_reg, phase_next;
    logic [5:0]            bit_count_reg, bit_count_next;
    logic [7:0]            request_byte_reg, request_byte_next;
    logic [31:0]           data_shift_reg, data_shift_next;
    logic                  parity_acc_reg, parity_acc_next;
    logic [2:0]            ack_shift_reg, ack_shift_next;
    logic [RETRY_BITS-1:0] attempts_reg, attempts_next;
    logic                  read_flag_reg, read_flag_next;

    logic [31:0]           limit_wide;
    logic [RETRY_BITS-1:0] attempts_init;
    outcome_t              outcome;
    logic                  lo, drv, done, succ;
    logic [1:0]            err;
    logic [31:0]           rw;
    logic [5:0]            bc_inc;

    assign limit_wide    = {16'd0, cfg.retry_limit};
    assign attempts_init = limit_wide[RETRY_BITS-1:0];
    assign bc_inc        = bit_count_reg + 6'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        request_byte_next = request_byte_reg;
        data_shift_next   = data_shift_reg;
        parity_acc_next   = parity_acc_reg;
        ack_shift_next    = ack_shift_reg;
        attempts_next     = attempts_reg;
        read_flag_next    = read_flag_reg;
        outcome           = OUT_NONE;
        lo                = 1'b0;
        drv               = 1'b1;
        done              = 1'b0;
        succ              = 1'b0;
        err               = ERR_NONE;
        rw                = 32'd0;

        if (item.kind == KIND_START)
        begin
            if (phase_reg == PH_IDLE)
            begin
                read_flag_next    = item.is_read;
                request_byte_next = build_request(item.to_access_port, item.is_read,
                                                  item.reg_offset);
                data_shift_next   = item.is_read ? 32'd0 : item.write_word;
                ack_shift_next    = 3'd0;
                parity_acc_next   = 1'b0;
                bit_count_next    = 6'd0;
                attempts_next     = attempts_init;
                if (attempts_init == '0)
                begin
                    done = 1'b1;
                    err  = ERR_RETRIES;
                end
                else
                begin
                    phase_next = PH_REQ;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_REQ:
                begin
                    lo             = request_byte_reg[bit_count_reg[2:0]];
                    bit_count_next = bc_inc;
                    if (bc_inc >= 6'd8)
                    begin
                        phase_next     = PH_TURN1;
                        bit_count_next = 6'd0;
                    end
                end
                PH_TURN1:
                begin
                    drv             = 1'b0;
                    ack_shift_next  = 3'd0;
                    parity_acc_next = 1'b0;
                    bit_count_next  = 6'd0;
                    phase_next      = PH_ACK;
                end
                PH_ACK:
                begin
                    drv = 1'b0;
                    if (bit_count_reg[1:0] != 2'd3)
                    begin
                        ack_shift_next[bit_count_reg[1:0]] =
                            ack_shift_reg[bit_count_reg[1:0]] | item.line_in;
                    end
                    bit_count_next = bc_inc;
                    if (bc_inc >= 6'd3)
                    begin
                        bit_count_next = 6'd0;
                        if (read_flag_reg)
                        begin
                            if (cfg.overrun_mode || ack_shift_next == ACK_OK)
                            begin
                                data_shift_next = 32'd0;
                                parity_acc_next = 1'b0;
                                phase_next      = PH_RDATA;
                            end
                            else
                            begin
                                phase_next = PH_TURN_END;
                            end
                        end
                        else
                        begin
                            phase_next = PH_WTURN;
                        end
                    end
                end
                PH_RDATA:
                begin
                    drv             = 1'b0;
                    parity_acc_next = parity_acc_reg ^ item.line_in;
                    if (!bit_count_reg[5])
                    begin
                        data_shift_next[bit_count_reg[4:0]] =
                            data_shift_reg[bit_count_reg[4:0]] | item.line_in;
                        bit_count_next = bc_inc;
                    end
                    else
                    begin
                        bit_count_next = 6'd0;
                        phase_next     = PH_TURN_END;
                    end
                end
                PH_TURN_END:
                begin
                    drv     = 1'b0;
                    outcome = parity_acc_reg ? OUT_RETRY : OUT_JUDGE;
                end
                PH_WTURN:
                begin
                    drv = 1'b0;
                    if (cfg.overrun_mode || ack_shift_reg == ACK_OK)
                    begin
                        bit_count_next = 6'd0;
                        phase_next     = PH_WDATA;
                    end
                    else
                    begin
                        outcome = OUT_JUDGE;
                    end
                end
                PH_WDATA:
                begin
                    lo = !bit_count_reg[5] ? data_shift_reg[bit_count_reg[4:0]]
                                           : ^data_shift_reg;
                    bit_count_next = bc_inc;
                    if (bc_inc >= 6'd33)
                    begin
                        outcome = OUT_JUDGE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (outcome == OUT_JUDGE)
            begin
                if (ack_shift_next == ACK_OK)
                begin
                    done = 1'b1;
                    succ = 1'b1;
                    if (read_flag_reg)
                    begin
                        rw = data_shift_next;
                    end
                end
                else if (ack_shift_next == ACK_WAIT)
                begin
                    outcome = OUT_RETRY;
                end
                else
                begin
                    done = 1'b1;
                    err  = ERR_ACK;
                end
            end
            if (outcome == OUT_RETRY)
            begin
                attempts_next = attempts_reg - RETRY_BITS'(1);
                if (attempts_next == '0)
                begin
                    done = 1'b1;
                    err  = ERR_RETRIES;
                end
                else
                begin
                    phase_next     = PH_REQ;
                    bit_count_next = 6'd0;
                end
            end
            if (done)
            begin
                phase_next     = PH_IDLE;
                bit_count_next = 6'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= 6'd0;
            request_byte_reg <= 8'd0;
            data_shift_reg   <= 32'd0;
            parity_acc_reg   <= 1'b0;
            ack_shift_reg    <= 3'd0;
            attempts_reg     <= '0;
            read_flag_reg    <= 1'b0;
        end
        else if (take)
        begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            request_byte_reg <= request_byte_next;
            data_shift_reg   <= data_shift_next;
            parity_acc_reg   <= parity_acc_next;
            ack_shift_reg    <= ack_shift_next;
            attempts_reg     <= attempts_next;
            read_flag_reg    <= read_flag_next;
        end
    end

    always_comb
    begin
        result.line_out   = lo;
        result.line_drive = drv;
        result.busy_res   = (phase_next != PH_IDLE);
        result.done_res   = done;
        result.success    = succ;
        result.error_code = err;
        result.last_ack   = ack_shift_next;
        result.read_word  = rw;
    end

endmodule

### sv/swd_host_transaction_engine.sv
// Top level of the serial wire debug host transaction engine.
// Depends on swdhte_pkg and swdhte_step.
//
// Usage: each transaction on the request channel (req_valid, req_stall) is
// either a start (kind 0), which when idle latches port, direction, register
// offset and write word, or a bit tick (kind 1) with the sampled line level.
// Every request transaction yields exactly one result transaction on the
// result channel (res_valid, res_stall) with the line bit to drive, the
// drive enable, progress flags, error code, last acknowledge and read word.
// An accepted transaction is held in the input register, and a single pass
// of next-state logic on it feeds the result register.
// Throughput is one transaction per cycle while res_stall stays low.
// When the receiver stalls, the result register holds, the input register
// fills, and req_stall rises until the result is taken.
// Configuration writes (cfg_valid, cfg_ready) are always taken: index 0 sets
// the retry limit, index 1 the overrun mode; other indexes are ignored.
// Reset clears both channels, returns the engine to idle, sets the retry
// limit to 100 and clears overrun mode.
module swd_host_transaction_engine #(
    parameter int RETRY_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        kind,
    input  logic        to_access_port,
    input  logic        is_read,
    input  logic [3:0]  reg_offset,
    input  logic [31:0] write_word,
    input  logic        line_in,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        line_out,
    output logic        line_drive,
    output logic        busy_res,
    output logic        done_res,
    output logic        success,
    output logic [1:0]  error_code,
    output logic [2:0]  last_ack,
    output logic [31:0] read_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import swdhte_pkg::*;

    logic    item_valid_reg, item_valid_next;
    item_t   item_reg;
    logic    res_valid_reg, res_valid_next;
    result_t result_reg;
    result_t step_result;
    cfg_t    cfg_reg;
    logic    advance, take, accept;

    assign advance   = !res_valid_reg || !res_stall;
    assign take      = item_valid_reg && advance;
    assign req_stall = item_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (take)
        begin
            item_valid_next = 1'b0;
        end
        res_valid_next = advance ? take : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind           <= kind;
            item_reg.to_access_port <= to_access_port;
            item_reg.is_read        <= is_read;
            item_reg.reg_offset     <= reg_offset;
            item_reg.write_word     <= write_word;
            item_reg.line_in        <= line_in;
        end
        if (take)
        begin
            result_reg <= step_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_limit  <= RETRY_LIMIT_RESET;
            cfg_reg.overrun_mode <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_RETRY_LIMIT)
            begin
                cfg_reg.retry_limit <= cfg_data;
            end
            else if (cfg_index == CFG_OVERRUN_MODE)
            begin
                cfg_reg.overrun_mode <= cfg_data[0];
            end
        end
    end

    swdhte_step #(
        .RETRY_BITS(RETRY_BITS)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (step_result)
    );

    assign res_valid  = res_valid_reg;
    assign line_out   = result_reg.line_out;
    assign line_drive = result_reg.line_drive;
    assign busy_res   = result_reg.busy_res;
    assign done_res   = result_reg.done_res;
    assign success    = result_reg.success;
    assign error_code = result_reg.error_code;
    assign last_ack   = result_reg.last_ack;
    assign read_word  = result_reg.read_word;

endmodule

### sv/swdhte_checker.sv
// Port-level checker for the serial wire debug host transaction engine,
// bound to the top level. Depends on swdhte_pkg.
module swdhte_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_stall,
    input logic        line_out,
    input logic        line_drive,
    input logic        busy_res,
    input logic        done_res,
    input logic        success,
    input logic [1:0]  error_code,
    input logic [31:0] read_word
);
    import swdhte_pkg::*;

    // A finished transaction leaves the engine idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> !busy_res)
        else $error("done result reports busy");

    // Success only on a finished transaction without an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && success |-> done_res && error_code == ERR_NONE)
        else $error("success without clean completion");

    // An error code only appears on a finished, unsuccessful transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && error_code != ERR_NONE |-> done_res && !success)
        else $error("error code outside completion");

    // A released line is always reported low, and read data needs success.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (!line_drive || !success) |->
            (line_drive || !line_out) && (success || read_word == 32'd0))
        else $error("released line high or stray read data");

    // A stalled result stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(read_word)
            && $stable(error_code) && $stable(done_res))
        else $error("stalled result changed");

endmodule

bind swd_host_transaction_engine swdhte_checker u_swdhte_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .line_out   (line_out),
    .line_drive (line_drive),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .success    (success),
    .error_code (error_code),
    .read_word  (read_word)
);

### test/swd_host_transaction_engine_tb.sv
// Testbench for the serial wire debug host transaction engine.
// Drives whole debug accesses bit by bit against a built-in model of the engine
// and checks every result transaction. Depends on swdhte_pkg and the engine RTL.
`timescale 1ns / 100ps

module swd_host_transaction_engine_tb;
    import swdhte_pkg::*;

    localparam logic [2:0] ACK_FAULT = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REQ,
        ST_TURN1,
        ST_ACK,
        ST_RDATA,
        ST_TURN_END,
        ST_WTURN,
        ST_WDATA
    } swd_phase_t;

    typedef enum logic [1:0] {
        VERDICT_NONE,
        VERDICT_JUDGE,
        VERDICT_RETRY
    } verdict_t;

    typedef struct packed {
        swd_phase_t  phase;
        logic [5:0]  bit_count;
        logic [7:0]  request_byte;
        logic [31:0] data_shift;
        logic        parity_acc;
        logic [2:0]  ack_shift;
        logic [15:0] attempts_left;
        logic        read_flag;
    } engine_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        req_valid      = 1'b0;
    logic        req_stall;
    logic        kind           = KIND_TICK;
    logic        to_access_port = 1'b0;
    logic        is_read        = 1'b0;
    logic [3:0]  reg_offset     = 4'd0;
    logic [31:0] write_word     = 32'd0;
    logic        line_in        = 1'b0;
    logic        res_valid;
    logic        res_stall      = 1'b0;
    logic        line_out;
    logic        line_drive;
    logic        busy_res;
    logic        done_res;
    logic        success;
    logic [1:0]  error_code;
    logic [2:0]  last_ack;
    logic [31:0] read_word;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index      = CFG_RETRY_LIMIT;
    logic [15:0] cfg_data       = 16'd0;

    item_t   outgoing_items[$];
    result_t predicted_results[$];
    bit      predicted_reads[$];

    engine_t model_st  = '0;
    engine_t plan_st   = '0;
    cfg_t    model_cfg = '{retry_limit: RETRY_LIMIT_RESET, overrun_mode: 1'b0};
    cfg_t    plan_cfg  = '{retry_limit: RETRY_LIMIT_RESET, overrun_mode: 1'b0};

    int items_sent  = 0;
    int items_taken = 0;
    bit idling_on   = 1'b1;
    int send_gap    = 0;
    int hold_gap    = 0;
    int planned_ticks;

    int mismatches     = 0;
    int results_seen   = 0;
    int accesses_done  = 0;
    int accesses_ok    = 0;
    int reads_ok       = 0;
    int ack_errors     = 0;
    int retry_errors   = 0;

    swd_host_transaction_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .kind           (kind),
        .to_access_port (to_access_port),
        .is_read        (is_read),
        .reg_offset     (reg_offset),
        .write_word     (write_word),
        .line_in        (line_in),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .line_out       (line_out),
        .line_drive     (line_drive),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .success        (success),
        .error_code     (error_code),
        .last_ack       (last_ack),
        .read_word      (read_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t swd_engine_step(inout engine_t s, input cfg_t c,
                                                input item_t it);
        result_t  r;
        verdict_t verdict;
        r = '0;
        r.line_drive = 1'b1;
        verdict = VERDICT_NONE;
        if (it.kind == KIND_START)
        begin
            if (s.phase == ST_IDLE)
            begin
                s.read_flag = it.is_read;
                s.request_byte = {2'b10,
                                  it.to_access_port ^ it.is_read ^ it.reg_offset[3]
                                      ^ it.reg_offset[2],
                                  it.reg_offset[3:2], it.is_read, it.to_access_port, 1'b1};
                s.data_shift = it.is_read ? 32'd0 : it.write_word;
                s.ack_shift = 3'd0;
                s.parity_acc = 1'b0;
                s.bit_count = 6'd0;
                s.attempts_left = c.retry_limit;
                if (s.attempts_left == 16'd0)
                begin
                    r.done_res = 1'b1;
                    r.error_code = ERR_RETRIES;
                end
                else
                begin
                    s.phase = ST_REQ;
                end
            end
        end
        else
        begin
            case (s.phase)
                ST_REQ:
                begin
                    r.line_out = s.request_byte[s.bit_count[2:0]];
                    s.bit_count = s.bit_count + 6'd1;
                    if (s.bit_count >= 6'd8)
                    begin
                        s.phase = ST_TURN1;
                        s.bit_count = 6'd0;
                    end
                end
                ST_TURN1:
                begin
                    r.line_drive = 1'b0;
                    s.ack_shift = 3'd0;
                    s.parity_acc = 1'b0;
                    s.bit_count = 6'd0;
                    s.phase = ST_ACK;
                end
                ST_ACK:
                begin
                    r.line_drive = 1'b0;
                    if (it.line_in)
                    begin
                        s.ack_shift[s.bit_count[1:0]] = 1'b1;
                    end
                    s.bit_count = s.bit_count + 6'd1;
                    if (s.bit_count >= 6'd3)
                    begin
                        s.bit_count = 6'd0;
                        if (!s.read_flag)
                        begin
                            s.phase = ST_WTURN;
                        end
                        else if (c.overrun_mode || s.ack_shift == ACK_OK)
                        begin
                            s.data_shift = 32'd0;
                            s.parity_acc = 1'b0;
                            s.phase = ST_RDATA;
                        end
                        else
                        begin
                            s.phase = ST_TURN_END;
                        end
                    end
                end
                ST_RDATA:
                begin
                    r.line_drive = 1'b0;
                    s.parity_acc = s.parity_acc ^ it.line_in;
                    if (s.bit_count < 6'd32)
                    begin
                        if (it.line_in)
                        begin
                            s.data_shift[s.bit_count[4:0]] = 1'b1;
                        end
                        s.bit_count = s.bit_count + 6'd1;
                    end
                    else
                    begin
                        s.bit_count = 6'd0;
                        s.phase = ST_TURN_END;
                    end
                end
                ST_TURN_END:
                begin
                    r.line_drive = 1'b0;
                    verdict = s.parity_acc ? VERDICT_RETRY : VERDICT_JUDGE;
                end
                ST_WTURN:
                begin
                    r.line_drive = 1'b0;
                    if (c.overrun_mode || s.ack_shift == ACK_OK)
                    begin
                        s.bit_count = 6'd0;
                        s.phase = ST_WDATA;
                    end
                    else
                    begin
                        verdict = VERDICT_JUDGE;
                    end
                end
                ST_WDATA:
                begin
                    r.line_out = (s.bit_count < 6'd32) ? s.data_shift[s.bit_count[4:0]]
                                                       : ^s.data_shift;
                    s.bit_count = s.bit_count + 6'd1;
                    if (s.bit_count >= 6'd33)
                    begin
                        verdict = VERDICT_JUDGE;
                    end
                end
                default:
                begin
                end
            endcase

            if (verdict == VERDICT_JUDGE)
            begin
                if (s.ack_shift == ACK_OK)
                begin
                    r.done_res = 1'b1;
                    r.success = 1'b1;
                    r.read_word = s.read_flag ? s.data_shift : 32'd0;
                end
                else if (s.ack_shift == ACK_WAIT)
                begin
                    verdict = VERDICT_RETRY;
                end
                else
                begin
                    r.done_res = 1'b1;
                    r.error_code = ERR_ACK;
                end
            end
            if (verdict == VERDICT_RETRY)
            begin
                s.attempts_left = s.attempts_left - 16'd1;
                if (s.attempts_left == 16'd0)
                begin
                    r.done_res = 1'b1;
                    r.error_code = ERR_RETRIES;
                end
                else
                begin
                    s.phase = ST_REQ;
                    s.bit_count = 6'd0;
                end
            end
            if (r.done_res)
            begin
                s.phase = ST_IDLE;
                s.bit_count = 6'd0;
            end
        end
        r.busy_res = (s.phase != ST_IDLE);
        r.last_ack = s.ack_shift;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 100)
        begin
            $display("MISMATCH at result %0d, %s: got %h, expected %h",
                     results_seen, field, got, want);
        end
        mismatches++;
    endtask

    task automatic compare_result(input result_t got, input result_t want);
        if (got.line_out !== want.line_out)
            report_mismatch("line_out", 32'(got.line_out), 32'(want.line_out));
        if (got.line_drive !== want.line_drive)
            report_mismatch("line_drive", 32'(got.line_drive), 32'(want.line_drive));
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
        if (got.done_res !== want.done_res)
            report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
        if (got.success !== want.success)
            report_mismatch("success", 32'(got.success), 32'(want.success));
        if (got.error_code !== want.error_code)
            report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
        if (got.last_ack !== want.last_ack)
            report_mismatch("last_ack", 32'(got.last_ack), 32'(want.last_ack));
        if (got.read_word !== want.read_word)
            report_mismatch("read_word", got.read_word, want.read_word);
    endtask

    always @(posedge clk)
    begin : monitor
        item_t   taken;
        result_t got;
        result_t want;
        bit      want_read;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_RETRY_LIMIT)
                    model_cfg.retry_limit = cfg_data;
                else if (cfg_index == CFG_OVERRUN_MODE)
                    model_cfg.overrun_mode = cfg_data[0];
            end
            if (res_valid && !res_stall)
            begin
                got = {line_out, line_drive, busy_res, done_res, success, error_code,
                       last_ack, read_word};
                results_seen++;
                if (predicted_results.size() == 0)
                begin
                    report_mismatch("result with no transaction outstanding",
                                    got.read_word, 32'd0);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    want_read = predicted_reads.pop_front();
                    compare_result(got, want);
                    if (want.done_res)
                    begin
                        accesses_done++;
                        if (want.success)
                            accesses_ok++;
                        if (want.success && want_read)
                            reads_ok++;
                        if (want.error_code == ERR_ACK)
                            ack_errors++;
                        if (want.error_code == ERR_RETRIES)
                            retry_errors++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                taken = {kind, to_access_port, is_read, reg_offset, write_word, line_in};
                want = swd_engine_step(model_st, model_cfg, taken);
                predicted_results.push_back(want);
                predicted_reads.push_back(model_st.read_flag);
                items_taken++;
            end
        end
    end

    always @(negedge clk)
    begin : driver
        item_t nxt;
        logic  hold;
        if (rst_n)
        begin
            hold = req_valid && (items_taken != items_sent);
            if (!hold)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (outgoing_items.size() == 0)
                begin
                    req_valid <= 1'b0;
                end
                else if (idling_on && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 5);
                    req_valid <= 1'b0;
                end
                else
                begin
                    nxt = outgoing_items.pop_front();
                    kind <= nxt.kind;
                    to_access_port <= nxt.to_access_port;
                    is_read <= nxt.is_read;
                    reg_offset <= nxt.reg_offset;
                    write_word <= nxt.write_word;
                    line_in <= nxt.line_in;
                    req_valid <= 1'b1;
                    items_sent++;
                end
            end
            if (hold_gap > 0)
            begin
                hold_gap--;
                res_stall <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                hold_gap = $urandom_range(0, 5);
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    function automatic item_t random_item(input logic k);
        item_t it;
        it.kind = k;
        it.to_access_port = 1'($urandom_range(0, 1));
        it.is_read = 1'($urandom_range(0, 1));
        it.reg_offset = 4'($urandom_range(0, 15));
        it.write_word = $urandom;
        it.line_in = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_ack(input int wait_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < wait_pct)
            return ACK_WAIT;
        if (roll < wait_pct + 8)
            return ACK_FAULT;
        if (roll < wait_pct + 12)
            return 3'($urandom_range(0, 7));
        return ACK_OK;
    endfunction

    task automatic plan_item(input item_t it);
        void'(swd_engine_step(plan_st, plan_cfg, it));
        outgoing_items.push_back(it);
    endtask

    task automatic run_access(input int wait_pct, input int bad_parity_pct);
        item_t       it;
        logic [2:0]  ack_plan;
        logic [31:0] word_plan;
        ack_plan = ACK_OK;
        word_plan = 32'd0;
        it = random_item(KIND_START);
        it.write_word = random_word();
        plan_item(it);
        planned_ticks++;
        while (plan_st.phase != ST_IDLE)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                plan_item(random_item(KIND_START));
            end
            it = random_item(KIND_TICK);
            if (plan_st.phase == ST_ACK)
            begin
                if (plan_st.bit_count == 6'd0)
                    ack_plan = pick_ack(wait_pct);
                it.line_in = ack_plan[plan_st.bit_count[1:0]];
            end
            else if (plan_st.phase == ST_RDATA)
            begin
                if (plan_st.bit_count == 6'd0)
                    word_plan = random_word();
                if (plan_st.bit_count < 6'd32)
                    it.line_in = word_plan[plan_st.bit_count[4:0]];
                else
                    it.line_in = plan_st.parity_acc ^ ($urandom_range(0, 99) < bad_parity_pct);
            end
            plan_item(it);
            planned_ticks++;
        end
    endtask

    task automatic random_phase(input int n_items, input int wait_pct,
                                input int bad_parity_pct);
        planned_ticks = 0;
        while (planned_ticks < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
                plan_item(random_item(KIND_TICK));
            run_access(wait_pct, bad_parity_pct);
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (outgoing_items.size() != 0 || req_valid || predicted_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] retries, input logic overrun);
        wait_drained();
        write_register(CFG_RETRY_LIMIT, retries);
        write_register(CFG_OVERRUN_MODE, {15'd0, overrun});
        plan_cfg.retry_limit = retries;
        plan_cfg.overrun_mode = overrun;
    endtask

    initial
    begin : stimulus
        item_t it;
        bit    busy_start_sent;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        configure(16'd0, 1'b0);
        it = '{kind: KIND_TICK, to_access_port: 1'b1, is_read: 1'b1, reg_offset: 4'hf,
               write_word: 32'hffff_ffff, line_in: 1'b1};
        plan_item(it);
        it = '{kind: KIND_START, to_access_port: 1'b0, is_read: 1'b0, reg_offset: 4'h0,
               write_word: 32'h0000_0000, line_in: 1'b0};
        plan_item(it);
        it = '{kind: KIND_START, to_access_port: 1'b1, is_read: 1'b1, reg_offset: 4'hf,
               write_word: 32'hffff_ffff, line_in: 1'b1};
        plan_item(it);

        configure(16'd1, 1'b0);
        it = '{kind: KIND_START, to_access_port: 1'b0, is_read: 1'b0, reg_offset: 4'h4,
               write_word: 32'h5a5a_c3c3, line_in: 1'b0};
        plan_item(it);
        busy_start_sent = 1'b0;
        while (plan_st.phase != ST_IDLE)
        begin
            it = random_item(KIND_TICK);
            it.line_in = (plan_st.phase == ST_ACK) ? ACK_WAIT[plan_st.bit_count[1:0]] : 1'b0;
            plan_item(it);
            if (!busy_start_sent && plan_st.phase == ST_REQ && plan_st.bit_count == 6'd3)
            begin
                plan_item(random_item(KIND_START));
                busy_start_sent = 1'b1;
            end
        end

        configure(16'hffff, 1'b1);
        random_phase(350, 20, 8);
        configure(16'd2, 1'b0);
        random_phase(300, 40, 10);
        configure(16'd1, 1'b1);
        random_phase(250, 25, 15);
        configure(16'd100, 1'b0);
        idling_on = 1'b0;
        random_phase(300, 20, 8);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Checked %0d results covering %0d finished accesses (%0d ok, %0d reads).",
                 results_seen, accesses_done, accesses_ok, reads_ok);
        $display("Error endings: %0d unexpected acknowledge, %0d retries exhausted.",
                 ack_errors, retry_errors);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Timeout with %0d results still outstanding.", predicted_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
